// ----- sv/sfd_pkg.sv -----
// Package for the spring force block: constants, item types and cell data types.
package sfd_pkg;

    // Fixed-point format and field widths.
    localparam int FRAC_BITS  = 16;
    localparam int UNIT_BITS  = 30;
    localparam int FIELD_W    = 32;
    localparam int D_W        = FIELD_W + 1;
    localparam int MAG_W      = FIELD_W;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int LEN_W      = SUM_W / 2;
    localparam int REM_W      = LEN_W + 3;
    localparam int Q_W        = UNIT_BITS + 1;
    localparam int M_W        = FIELD_W + LEN_W - FRAC_BITS;
    localparam int MH_W       = M_W - FIELD_W;

    // Chain lengths and total latency.
    localparam int SQRT_STEPS = LEN_W;
    localparam int DIV_STEPS  = Q_W;
    localparam int LATENCY    = 3 + SQRT_STEPS + 2 + DIV_STEPS + 2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REST      = 8'd1;
    localparam logic [FIELD_W-1:0]   ONE_FIXED     = FIELD_W'(1) << FRAC_BITS;

    // One input item.
    typedef struct packed {
        logic signed [FIELD_W-1:0] particle_x;
        logic signed [FIELD_W-1:0] particle_y;
        logic signed [FIELD_W-1:0] particle_z;
        logic signed [FIELD_W-1:0] other_x;
        logic signed [FIELD_W-1:0] other_y;
        logic signed [FIELD_W-1:0] other_z;
        logic [FIELD_W-1:0]        particle_mass;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic signed [FIELD_W-1:0] force_x;
        logic signed [FIELD_W-1:0] force_y;
        logic signed [FIELD_W-1:0] force_z;
        logic                      skipped;
    } out_item_t;

    // Data handed along the square-root chain.
    typedef struct packed {
        logic                       skip;
        logic [2:0]                 dneg;
        logic [2:0][MAG_W-1:0]      mag;
        logic [SUM_W-1:0]           rad;
        logic [REM_W-1:0]           rem;
        logic [LEN_W-1:0]           root;
    } sqrt_data_t;

    // Data handed along the divider chain.
    typedef struct packed {
        logic                       skip;
        logic [2:0]                 dneg;
        logic                       stretched;
        logic                       zero;
        logic [LEN_W-1:0]           len;
        logic [M_W-1:0]             m;
        logic [2:0][LEN_W-1:0]      rem;
        logic [2:0][Q_W-1:0]        quo;
        logic [2:0]                 nbit;
    } div_data_t;

endpackage

// ----- sv/sfd_sqrt_cell.sv -----
// One cell of the square-root chain: resolves one root bit per item.
module sfd_sqrt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  sfd_pkg::sqrt_data_t in_data,
    output logic                out_valid,
    output sfd_pkg::sqrt_data_t out_data
);

    localparam int SH_W = sfd_pkg::REM_W + 2;

    logic                   valid_reg;
    sfd_pkg::sqrt_data_t    data_reg;
    sfd_pkg::sqrt_data_t    data_next;
    logic [SH_W-1:0]        rem_sh;
    logic [SH_W-1:0]        trial;
    logic [SH_W-1:0]        diff;
    logic                   take;

    // Bring down the next bit pair and try the trial subtrahend.
    always_comb
    begin
        rem_sh = {in_data.rem, in_data.rad[sfd_pkg::SUM_W-1 -: 2]};
        trial  = SH_W'({in_data.root, 2'b01});
        take   = (rem_sh >= trial);
        diff   = rem_sh - trial;
        data_next      = in_data;
        data_next.rad  = {in_data.rad[sfd_pkg::SUM_W-3:0], 2'b00};
        data_next.rem  = take ? diff[sfd_pkg::REM_W-1:0] : rem_sh[sfd_pkg::REM_W-1:0];
        data_next.root = {in_data.root[sfd_pkg::LEN_W-2:0], take};
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- sv/sfd_div_cell.sv -----
// One cell of the divider chain: resolves one quotient bit in each of three lanes.
module sfd_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  sfd_pkg::div_data_t in_data,
    output logic               out_valid,
    output sfd_pkg::div_data_t out_data
);

    localparam int SH_W = sfd_pkg::LEN_W + 1;

    logic                  valid_reg;
    sfd_pkg::div_data_t    data_reg;
    sfd_pkg::div_data_t    data_next;
    logic [SH_W-1:0]       sh [3];
    logic [SH_W-1:0]       diff [3];
    logic [2:0]            take;

    // Restoring division step in each lane.
    always_comb
    begin
        data_next = in_data;
        for (int i = 0; i < 3; i++)
        begin
            sh[i]   = {in_data.rem[i], in_data.nbit[i]};
            take[i] = (sh[i] >= {1'b0, in_data.len});
            diff[i] = sh[i] - {1'b0, in_data.len};
            data_next.rem[i] = take[i] ? diff[i][sfd_pkg::LEN_W-1:0]
                                       : sh[i][sfd_pkg::LEN_W-1:0];
            data_next.quo[i] = {in_data.quo[i][sfd_pkg::Q_W-2:0], take[i]};
        end
        data_next.nbit = 3'b000;
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- sv/spring_force_3d_top.sv -----
// Top level of the spring force block: input stages, cell chains and output stages.
// done rises after stages A, B, C, the root chain, S1, S2, the divider chain and F1.
// Throughput: one item per cycle, set by the root and quotient cell chains.
// Each result is shown for one cycle with done; the receiver cannot stall.
// Reset clears all valid bits, holds busy high while asserted, and sets
// stiffness and rest length to 1.0.
module spring_force_3d_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  sfd_pkg::in_item_t                   item,
    output logic                                done,
    output sfd_pkg::out_item_t                  result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sfd_pkg::FIELD_W-1:0]         cfg_data
);

    localparam int FW  = sfd_pkg::FIELD_W;
    localparam int MW  = sfd_pkg::MAG_W;
    localparam int LW  = sfd_pkg::LEN_W;
    localparam int QW  = sfd_pkg::Q_W;
    localparam int M_W = sfd_pkg::M_W;
    localparam int PL_W = FW + QW;
    localparam int PH_W = sfd_pkg::MH_W + QW;
    localparam int P_W  = M_W + QW;
    localparam int PS_W = P_W - sfd_pkg::UNIT_BITS;

    // Control and configuration.
    logic                 busy_reg;
    logic [FW-1:0]        stiffness_reg;
    logic [FW-1:0]        rest_reg;
    logic                 accept;

    // Stage A: differences.
    logic                 a_valid_reg;
    logic                 a_skip_reg;
    logic [2:0]           a_dneg_reg;
    logic [2:0][MW-1:0]   a_mag_reg;
    logic [2:0]           a_dneg_next;
    logic [2:0][MW-1:0]   a_mag_next;
    logic [sfd_pkg::D_W-1:0] dv [3];
    logic signed [FW-1:0] pos_p [3];
    logic signed [FW-1:0] pos_o [3];

    // Stage B: squares.
    logic                 b_valid_reg;
    logic                 b_skip_reg;
    logic [2:0]           b_dneg_reg;
    logic [2:0][MW-1:0]   b_mag_reg;
    logic [2:0][sfd_pkg::SQ_W-1:0] b_sq_reg;

    // Stage C: sum of squares.
    logic                 c_valid_reg;
    sfd_pkg::sqrt_data_t  c_data_reg;

    // Root chain.
    logic                 sq_valid [sfd_pkg::SQRT_STEPS+1];
    sfd_pkg::sqrt_data_t  sq_data  [sfd_pkg::SQRT_STEPS+1];

    // Stage S1: displacement.
    logic                 s1_valid_reg;
    logic                 s1_skip_reg;
    logic [2:0]           s1_dneg_reg;
    logic [2:0][MW-1:0]   s1_mag_reg;
    logic [LW-1:0]        s1_len_reg;
    logic                 s1_stretched_reg;
    logic [LW-1:0]        s1_disp_reg;
    logic [LW-1:0]        len_w;
    logic                 stretched_w;

    // Stage S2: spring magnitude, divider setup.
    logic                 s2_valid_reg;
    sfd_pkg::div_data_t   s2_data_reg;
    sfd_pkg::div_data_t   s2_data_next;
    logic [FW+LW-1:0]     k_prod;

    // Divider chain.
    logic                 dv_valid [sfd_pkg::DIV_STEPS+1];
    sfd_pkg::div_data_t   dv_data  [sfd_pkg::DIV_STEPS+1];

    // Stage F1: partial products.
    logic                 f1_valid_reg;
    logic                 f1_skip_reg;
    logic                 f1_kill_reg;
    logic [2:0]           f1_neg_reg;
    logic [2:0][PL_W-1:0] f1_pl_reg;
    logic [2:0][PH_W-1:0] f1_ph_reg;

    // Output stage.
    logic                 done_reg;
    sfd_pkg::out_item_t   result_reg;
    sfd_pkg::out_item_t   result_next;
    logic [P_W-1:0]       p_full [3];
    logic [PS_W-1:0]      p_mag  [3];
    logic [FW-1:0]        limit  [3];
    logic [FW-1:0]        f_sat  [3];
    logic [FW-1:0]        f_out  [3];

    assign accept    = start && !busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = 1'b1;

    // Busy only while reset holds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg <= sfd_pkg::ONE_FIXED;
            rest_reg      <= sfd_pkg::ONE_FIXED;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sfd_pkg::REG_STIFFNESS: stiffness_reg <= cfg_data;
                sfd_pkg::REG_REST:      rest_reg      <= cfg_data;
                default:                ;
            endcase
        end
    end

    // Differences and their magnitudes.
    always_comb
    begin
        pos_p[0] = item.particle_x;
        pos_p[1] = item.particle_y;
        pos_p[2] = item.particle_z;
        pos_o[0] = item.other_x;
        pos_o[1] = item.other_y;
        pos_o[2] = item.other_z;
        for (int i = 0; i < 3; i++)
        begin
            dv[i] = {pos_p[i][FW-1], pos_p[i]} - {pos_o[i][FW-1], pos_o[i]};
            a_dneg_next[i] = dv[i][sfd_pkg::D_W-1];
            a_mag_next[i]  = dv[i][sfd_pkg::D_W-1] ? MW'(~dv[i] + 1'b1) : MW'(dv[i]);
        end
    end

    // Valid bits of the front and back stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            a_valid_reg  <= accept;
            b_valid_reg  <= a_valid_reg;
            c_valid_reg  <= b_valid_reg;
            s1_valid_reg <= sq_valid[sfd_pkg::SQRT_STEPS];
            s2_valid_reg <= s1_valid_reg;
            f1_valid_reg <= dv_valid[sfd_pkg::DIV_STEPS];
            done_reg     <= f1_valid_reg;
        end
    end

    // Front stages: differences, squares, sum.
    always_ff @(posedge clk)
    begin
        a_skip_reg <= (item.particle_mass[FW-1:sfd_pkg::FRAC_BITS] == '0);
        a_dneg_reg <= a_dneg_next;
        a_mag_reg  <= a_mag_next;
        b_skip_reg <= a_skip_reg;
        b_dneg_reg <= a_dneg_reg;
        b_mag_reg  <= a_mag_reg;
        for (int i = 0; i < 3; i++)
        begin
            b_sq_reg[i] <= a_mag_reg[i] * a_mag_reg[i];
        end
        c_data_reg.skip <= b_skip_reg;
        c_data_reg.dneg <= b_dneg_reg;
        c_data_reg.mag  <= b_mag_reg;
        c_data_reg.rad  <= sfd_pkg::SUM_W'(b_sq_reg[0]) + sfd_pkg::SUM_W'(b_sq_reg[1])
                         + sfd_pkg::SUM_W'(b_sq_reg[2]);
        c_data_reg.rem  <= '0;
        c_data_reg.root <= '0;
    end

    // Square-root chain, one root bit per cell.
    assign sq_valid[0] = c_valid_reg;
    assign sq_data[0]  = c_data_reg;

    for (genvar g = 0; g < sfd_pkg::SQRT_STEPS; g++)
    begin : g_sqrt
        sfd_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[g]),
            .in_data   (sq_data[g]),
            .out_valid (sq_valid[g+1]),
            .out_data  (sq_data[g+1])
        );
    end

    // Displacement from rest length.
    assign len_w       = sq_data[sfd_pkg::SQRT_STEPS].root;
    assign stretched_w = (len_w > LW'(rest_reg));

    always_ff @(posedge clk)
    begin
        s1_skip_reg      <= sq_data[sfd_pkg::SQRT_STEPS].skip;
        s1_dneg_reg      <= sq_data[sfd_pkg::SQRT_STEPS].dneg;
        s1_mag_reg       <= sq_data[sfd_pkg::SQRT_STEPS].mag;
        s1_len_reg       <= len_w;
        s1_stretched_reg <= stretched_w;
        s1_disp_reg      <= stretched_w ? (len_w - LW'(rest_reg)) : (LW'(rest_reg) - len_w);
    end

    // Spring magnitude and divider setup.
    assign k_prod = stiffness_reg * s1_disp_reg;

    always_comb
    begin
        s2_data_next.skip      = s1_skip_reg;
        s2_data_next.dneg      = s1_dneg_reg;
        s2_data_next.stretched = s1_stretched_reg;
        s2_data_next.zero      = (s1_len_reg == '0);
        s2_data_next.len       = s1_len_reg;
        s2_data_next.m         = k_prod[FW+LW-1:sfd_pkg::FRAC_BITS];
        for (int i = 0; i < 3; i++)
        begin
            s2_data_next.rem[i]  = LW'(s1_mag_reg[i][MW-1:1]);
            s2_data_next.quo[i]  = '0;
            s2_data_next.nbit[i] = s1_mag_reg[i][0];
        end
    end

    always_ff @(posedge clk)
    begin
        s2_data_reg <= s2_data_next;
    end

    // Divider chain, one quotient bit per cell in each lane.
    assign dv_valid[0] = s2_valid_reg;
    assign dv_data[0]  = s2_data_reg;

    for (genvar g = 0; g < sfd_pkg::DIV_STEPS; g++)
    begin : g_div
        sfd_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[g]),
            .in_data   (dv_data[g]),
            .out_valid (dv_valid[g+1]),
            .out_data  (dv_data[g+1])
        );
    end

    // Partial products of magnitude and unit direction.
    always_ff @(posedge clk)
    begin
        f1_skip_reg <= dv_data[sfd_pkg::DIV_STEPS].skip;
        f1_kill_reg <= dv_data[sfd_pkg::DIV_STEPS].skip || dv_data[sfd_pkg::DIV_STEPS].zero;
        for (int i = 0; i < 3; i++)
        begin
            f1_neg_reg[i] <= dv_data[sfd_pkg::DIV_STEPS].dneg[i]
                           ^ dv_data[sfd_pkg::DIV_STEPS].stretched;
            f1_pl_reg[i]  <= dv_data[sfd_pkg::DIV_STEPS].m[FW-1:0]
                           * dv_data[sfd_pkg::DIV_STEPS].quo[i];
            f1_ph_reg[i]  <= dv_data[sfd_pkg::DIV_STEPS].m[M_W-1:FW]
                           * dv_data[sfd_pkg::DIV_STEPS].quo[i];
        end
    end

    // Combine, scale, saturate, apply the sign, and zero skipped or zero-length items.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_full[i] = {f1_ph_reg[i], {FW{1'b0}}} + P_W'(f1_pl_reg[i]);
            p_mag[i]  = p_full[i][P_W-1:sfd_pkg::UNIT_BITS];
            limit[i]  = f1_neg_reg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            f_sat[i]  = (p_mag[i] > PS_W'(limit[i])) ? limit[i] : p_mag[i][FW-1:0];
            f_out[i]  = f1_kill_reg ? '0 : (f1_neg_reg[i] ? (~f_sat[i] + 1'b1) : f_sat[i]);
        end
        result_next.force_x = f_out[0];
        result_next.force_y = f_out[1];
        result_next.force_z = f_out[2];
        result_next.skipped = f1_skip_reg;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    // Every accepted item comes out after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(sfd_pkg::LATENCY) done)
        else $error("accepted item did not complete on time");

    // No result appears without an item accepted the fixed latency before.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, sfd_pkg::LATENCY))
        else $error("result without an accepted item");

    // A skipped item carries zero force.
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.skipped) |->
            (result.force_x == '0 && result.force_y == '0 && result.force_z == '0))
        else $error("skipped item has nonzero force");
`endif

endmodule

// ----- tb/sv/tb_spring_force_3d_top.sv -----
// Testbench for the spring force block: random and directed items checked against a predictor.
module tb_spring_force_3d_top;

    // Scoreboard that predicts spring forces and checks each result.
    class force_scoreboard;
        logic [31:0]         stiffness;
        logic [31:0]         rest;
        sfd_pkg::out_item_t  pending_forces[$];
        int                  errors;

        function new();
            stiffness = 32'd65536;
            rest = 32'd65536;
            errors = 0;
        endfunction

        // Floor square root of a 66-bit sum.
        function automatic logic [32:0] root_of(logic [65:0] n);
            logic [32:0] r;
            logic [35:0] rm;
            logic [35:0] trial;
            int i;
            r = 0;
            rm = 0;
            for (i = 32; i >= 0; i--)
            begin
                rm = (rm << 2) | 36'(n[2*i +: 2]);
                trial = 36'({r, 2'b01});
                if (rm >= trial)
                begin
                    rm = rm - trial;
                    r = {r[31:0], 1'b1};
                end
                else
                    r = {r[31:0], 1'b0};
            end
            return r;
        endfunction

        // Works out the force for one accepted item.
        function automatic sfd_pkg::out_item_t spring_force(sfd_pkg::in_item_t it);
            sfd_pkg::out_item_t o;
            logic signed [32:0] d[3];
            logic [32:0] mag[3];
            logic [65:0] sum;
            logic [32:0] len;
            logic [32:0] disp;
            logic [64:0] m;
            logic [127:0] u;
            logic [127:0] p;
            logic [32:0] lim;
            logic [31:0] f;
            logic stretched;
            logic neg;
            int i;
            o = '0;
            if (it.particle_mass < sfd_pkg::ONE_FIXED)
            begin
                o.skipped = 1'b1;
                return o;
            end
            d[0] = 33'(it.particle_x) - 33'(it.other_x);
            d[1] = 33'(it.particle_y) - 33'(it.other_y);
            d[2] = 33'(it.particle_z) - 33'(it.other_z);
            sum = 0;
            for (i = 0; i < 3; i++)
            begin
                mag[i] = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
                sum = sum + 66'(mag[i]) * 66'(mag[i]);
            end
            len = root_of(sum);
            if (len == 0)
                return o;
            stretched = len > 33'(rest);
            disp = stretched ? len - 33'(rest) : 33'(rest) - len;
            m = 65'((65'(stiffness) * 65'(disp)) >> sfd_pkg::FRAC_BITS);
            for (i = 0; i < 3; i++)
            begin
                u = (128'(mag[i]) << sfd_pkg::UNIT_BITS) / 128'(len);
                p = (128'(m) * u) >> sfd_pkg::UNIT_BITS;
                neg = d[i] < 0 ? !stretched : stretched;
                lim = neg ? 33'h080000000 : 33'h07fffffff;
                f = (p > 128'(lim)) ? lim[31:0] : p[31:0];
                if (d[i] == 0 || f == 0)
                    continue;
                f = neg ? -f : f;
                if (i == 0) o.force_x = f;
                else if (i == 1) o.force_y = f;
                else o.force_z = f;
            end
            return o;
        endfunction

        function void note_item(sfd_pkg::in_item_t it);
            pending_forces.push_back(spring_force(it));
        endfunction

        function void check_result(sfd_pkg::out_item_t r);
            sfd_pkg::out_item_t e;
            if (pending_forces.size() == 0)
            begin
                $error("result with no expectation: %h", r);
                errors++;
                return;
            end
            e = pending_forces.pop_front();
            if (r.force_x !== e.force_x)
            begin
                $error("force_x expected %0d actual %0d", e.force_x, r.force_x);
                errors++;
            end
            if (r.force_y !== e.force_y)
            begin
                $error("force_y expected %0d actual %0d", e.force_y, r.force_y);
                errors++;
            end
            if (r.force_z !== e.force_z)
            begin
                $error("force_z expected %0d actual %0d", e.force_z, r.force_z);
                errors++;
            end
            if (r.skipped !== e.skipped)
            begin
                $error("skipped expected %0d actual %0d", e.skipped, r.skipped);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 5000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    sfd_pkg::in_item_t item;
    logic done;
    sfd_pkg::out_item_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [sfd_pkg::FIELD_W-1:0] cfg_data;

    force_scoreboard sb;
    int idle_cycles;
    bit calm_phase;

    spring_force_3d_top DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Checks results and watches for a stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(result);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Writes one configuration register, then leaves the channel idle until the next clock edge.
    task automatic write_reg(logic [sfd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == sfd_pkg::REG_STIFFNESS)
            sb.stiffness = val;
        else if (idx == sfd_pkg::REG_REST)
            sb.rest = val;
        @(posedge clk);
    endtask

    // Sends one item, sometimes with a random gap before it outside the calm phase.
    task automatic send_item(sfd_pkg::in_item_t it);
        int gap;
        if (!calm_phase && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        do @(posedge clk); while (busy);
        sb.note_item(it);
    endtask

    // Stops sending and waits for every expected result.
    task automatic drain();
        int n;
        start <= 1'b0;
        n = 0;
        while (sb.pending_forces.size() != 0 && n < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (sfd_pkg::LATENCY + 5) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
            default: return 32'($signed($urandom_range(0, 2048)) - 1024);
        endcase
    endfunction

    function automatic sfd_pkg::in_item_t rand_item();
        sfd_pkg::in_item_t it;
        int mode;
        mode = $urandom_range(0, 2);
        it.particle_x = rand_coord(mode);
        it.particle_y = rand_coord(mode);
        it.particle_z = rand_coord(mode);
        it.other_x = $urandom_range(0, 7) == 0 ? it.particle_x : rand_coord(mode);
        it.other_y = rand_coord(mode);
        it.other_z = $urandom_range(0, 7) == 0 ? it.particle_z : rand_coord(mode);
        case ($urandom_range(0, 7))
            0: it.particle_mass = $urandom_range(0, 65535);
            1: it.particle_mass = $urandom();
            default: it.particle_mass = $urandom_range(65536, 10 * 65536);
        endcase
        return it;
    endfunction

    function automatic sfd_pkg::in_item_t make_item(logic [31:0] px, logic [31:0] py,
                                                    logic [31:0] pz, logic [31:0] ox,
                                                    logic [31:0] oy, logic [31:0] oz,
                                                    logic [31:0] ms);
        sfd_pkg::in_item_t it;
        it.particle_x = px; it.particle_y = py; it.particle_z = pz;
        it.other_x = ox; it.other_y = oy; it.other_z = oz;
        it.particle_mass = ms;
        return it;
    endfunction

    initial
    begin
        logic [31:0] stiff_set[6];
        logic [31:0] rest_set[6];
        int phase;
        int k;
        sb = new();
        idle_cycles = 0;
        calm_phase = 0;
        rst_n = 0;
        start = 0;
        item = '0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);

        // Directed items at the reset settings.
        send_item(make_item(32'd0, 0, 0, 0, 0, 0, 32'd65535));
        send_item(make_item(32'd100, 5, 7, 100, 5, 7, 32'd65536));
        send_item(make_item(32'd65536, 0, 0, 0, 0, 0, 32'hffffffff));
        send_item(make_item(32'd131072, 0, 0, 0, 0, 0, 32'd65536));
        send_item(make_item(32'd0, 0, 0, 32'd0, 32'd32768, 0, 32'd65536));
        send_item(make_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                            32'h80000000, 32'h80000000, 32'h80000000, 32'd65536));
        send_item(make_item(32'h80000000, 32'h7fffffff, 32'h80000000,
                            32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'hffffffff));
        send_item(make_item(32'hffffffff, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'd70000));
        send_item(make_item(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h00010000, 32'h0));
        drain();

        // Unknown index must not disturb anything.
        write_reg(8'd2, 32'h12345678);
        write_reg(8'hff, 32'hffffffff);

        stiff_set = '{32'hffffffff, 32'd0, 32'd65536, 32'h00100000, 32'd1, 32'h7fffffff};
        rest_set = '{32'd0, 32'hffffffff, 32'd65536, 32'h00050000, 32'd1, 32'h80000000};
        for (phase = 0; phase < 6; phase++)
        begin
            write_reg(sfd_pkg::REG_STIFFNESS, stiff_set[phase]);
            write_reg(sfd_pkg::REG_REST, rest_set[phase]);
            if (phase == 0)
            begin
                send_item(make_item(32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 32'd65536));
                send_item(make_item(32'h80000000, 0, 0, 32'h7fffffff, 0, 0, 32'd65536));
            end
            if (phase == 2)
                send_item(make_item(32'd65536, 0, 0, 0, 0, 0, 32'd65536));
            calm_phase = (phase == 5);
            for (k = 0; k < 200; k++)
                send_item(rand_item());
            drain();
        end

        if (sb.errors == 0 && sb.pending_forces.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
